FILE: rtl/ssb_pkg.sv
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types, widths and the ordering function of the sprite batcher.
// ----------------------------------------------------------------------------
package ssb_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DEPTH_W     = 16;
    localparam int TEX_W       = 16;
    localparam int START_W     = 6;
    localparam int RCOUNT_W    = 7;
    localparam int ENTRY_W     = DEPTH_W + TEX_W;

    // sort modes
    localparam logic [1:0] MODE_DEPTH_UP   = 2'd0;
    localparam logic [1:0] MODE_DEPTH_DOWN = 2'd1;
    localparam logic [1:0] MODE_TEX_UP     = 2'd2;
    localparam logic [1:0] MODE_NONE       = 2'd3;

    // actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // register byte addresses
    localparam logic [2:0] ADDR_SORT_MODE = 3'd0;

    typedef struct packed {
        logic                      action;
        logic signed [DEPTH_W-1:0] sprite_depth;
        logic [TEX_W-1:0]          sprite_texture;
    } req_word_t;

    typedef struct packed {
        logic [START_W-1:0]  run_start;
        logic [RCOUNT_W-1:0] run_count;
        logic [TEX_W-1:0]    run_texture;
        logic                last_run;
        logic                dropped_any;
    } rsp_word_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic flush;
        logic rank_rd;
        logic rank_lat;
        logic scan;
        logic place;
        logic emit_rd;
        logic emit_take;
        logic emit_last;
    } ssb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic scan_done;
        logic last_i;
        logic last_p;
        logic advance;
        logic slot_free;
    } ssb_stat_t;

    // true when entry a must be placed strictly after entry b
    function automatic logic goes_after(input logic [1:0] mode,
                                        input logic signed [DEPTH_W-1:0] da,
                                        input logic [TEX_W-1:0] ta,
                                        input logic signed [DEPTH_W-1:0] db,
                                        input logic [TEX_W-1:0] tb);
        logic r;
        case (mode)
            MODE_DEPTH_UP:   r = da > db;
            MODE_DEPTH_DOWN: r = da < db;
            MODE_TEX_UP:     r = ta > tb;
            default:         r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/sprite_sort_and_texture_batch_core.sv
// A new word is accepted every cycle while idle. A flush of n entries ranks
// each entry by a full scan of the entry RAM, then reads each entry from the
// sorted RAM in turn and issues the last run once the output is not stalled;
// the input is stalled until the last run is issued.
// Reset empties the queue, clears the overflow flag and sets sort_mode to 3.
// ----------------------------------------------------------------------------
// sprite_sort_and_texture_batch_core
// Sprite queue with stable sort by mode and grouping of equal-texture runs.
// ----------------------------------------------------------------------------
module sprite_sort_and_texture_batch_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               req_valid,
    output logic               req_stall,
    input  ssb_pkg::req_word_t req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ssb_pkg::rsp_word_t rsp_word
);
    import ssb_pkg::*;

    logic [1:0] mode_reg;
    ssb_cmd_t   cmd;
    ssb_stat_t  stat;
    logic       sel_mode;

    // register select by word address, byte offset ignored
    assign sel_mode = (paddr[2] == ADDR_SORT_MODE[2]);

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NONE;
        end
        else if (psel && penable && pwrite && sel_mode)
        begin
            mode_reg <= pwdata[1:0];
        end
    end
    assign prdata = sel_mode ? {30'd0, mode_reg} : 32'd0;

    ssb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req_word.action),
        .req_stall  (req_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    ssb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .sort_mode (mode_reg),
        .req_word  (req_word),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

FILE: rtl/ssb_ram.sv
// ----------------------------------------------------------------------------
// ssb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/ssb_ctrl.sv
// ----------------------------------------------------------------------------
// ssb_ctrl
// Sequencer: load, rank each entry by a full scan, place it, then emit runs.
// ----------------------------------------------------------------------------
module ssb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_action,
    output logic              req_stall,
    input  ssb_pkg::ssb_stat_t stat,
    output ssb_pkg::ssb_cmd_t  cmd
);
    import ssb_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_RANK_RD   = 8'b0000_0010,
        S_RANK_LAT  = 8'b0000_0100,
        S_SCAN      = 8'b0000_1000,
        S_PLACE     = 8'b0001_0000,
        S_EMIT_RD   = 8'b0010_0000,
        S_EMIT_DAT  = 8'b0100_0000,
        S_EMIT_LAST = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    // command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load  = accept && (req_action == ACT_LOAD);
                cmd.flush = accept && (req_action == ACT_FLUSH);
                if (cmd.flush && !stat.count_zero)
                begin
                    state_next = S_RANK_RD;
                end
            end
            S_RANK_RD:
            begin
                cmd.rank_rd = 1'b1;
                state_next  = S_RANK_LAT;
            end
            S_RANK_LAT:
            begin
                cmd.rank_lat = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = stat.last_i ? S_EMIT_RD : S_RANK_RD;
            end
            S_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_DAT;
            end
            S_EMIT_DAT:
            begin
                cmd.emit_take = 1'b1;
                if (stat.advance)
                begin
                    state_next = stat.last_p ? S_EMIT_LAST : S_EMIT_RD;
                end
            end
            S_EMIT_LAST:
            begin
                cmd.emit_last = 1'b1;
                if (stat.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/ssb_datapath.sv
// ----------------------------------------------------------------------------
// ssb_datapath
// Entry store, rank counter, sorted texture store, run builder and output word.
// ----------------------------------------------------------------------------
module ssb_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         sort_mode,
    input  ssb_pkg::req_word_t req_word,
    input  ssb_pkg::ssb_cmd_t  cmd,
    output ssb_pkg::ssb_stat_t stat,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ssb_pkg::rsp_word_t rsp_word
);
    import ssb_pkg::*;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic [IDX_W-1:0]  rank_reg, rank_next;
    logic [IDX_W-1:0]  p_reg, p_next;
    logic signed [DEPTH_W-1:0] key_d_reg, key_d_next;
    logic [TEX_W-1:0]  key_t_reg, key_t_next;
    logic [IDX_W-1:0]  rs_reg, rs_next;
    logic [CNT_W-1:0]  rc_reg, rc_next;
    logic [TEX_W-1:0]  rt_reg, rt_next;
    logic              rv_reg, rv_next;
    rsp_word_t         rw_reg, rw_next;

    logic              a_we, a_re, b_re;
    logic [IDX_W-1:0]  a_raddr;
    logic [ENTRY_W-1:0] a_rdata;
    logic [TEX_W-1:0]  b_rdata;
    logic signed [DEPTH_W-1:0] ent_d;
    logic [TEX_W-1:0]  ent_t;
    logic [CNT_W-1:0]  last_idx;
    logic              precedes, first_p, match;

    assign a_we    = cmd.load && (count_reg < CNT_W'(QUEUE_DEPTH));
    assign a_re    = cmd.rank_rd || (cmd.scan && (j_reg < count_reg));
    assign a_raddr = cmd.rank_rd ? i_reg : j_reg[IDX_W-1:0];
    assign b_re    = cmd.emit_rd;

    ssb_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_entry_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({req_word.sprite_depth, req_word.sprite_texture}),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    ssb_ram #(.WIDTH(TEX_W), .DEPTH(QUEUE_DEPTH)) u_sorted_ram (
        .clk   (clk),
        .we    (cmd.place),
        .waddr (rank_reg),
        .wdata (key_t_reg),
        .re    (b_re),
        .raddr (p_reg),
        .rdata (b_rdata)
    );

    assign ent_d = a_rdata[ENTRY_W-1:TEX_W];
    assign ent_t = a_rdata[TEX_W-1:0];

    // stable order: j precedes i on a strict key win or on a tie with earlier arrival
    assign precedes = goes_after(sort_mode, key_d_reg, key_t_reg, ent_d, ent_t) ||
                      (!goes_after(sort_mode, ent_d, ent_t, key_d_reg, key_t_reg) &&
                       (pidx_reg < i_reg));

    assign last_idx = count_reg - CNT_W'(1);
    assign first_p  = (p_reg == '0);
    assign match    = (b_rdata == rt_reg);

    assign stat.count_zero = (count_reg == '0);
    assign stat.scan_done  = (j_reg == count_reg) && !pend_reg;
    assign stat.last_i     = (CNT_W'(i_reg) == last_idx);
    assign stat.last_p     = (CNT_W'(p_reg) == last_idx);
    assign stat.slot_free  = !rv_reg || !rsp_stall;
    assign stat.advance    = first_p || match || stat.slot_free;

    // next-state logic
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        rank_next  = rank_reg;
        p_next     = p_reg;
        key_d_next = key_d_reg;
        key_t_next = key_t_reg;
        rs_next    = rs_reg;
        rc_next    = rc_reg;
        rt_next    = rt_reg;
        rw_next    = rw_reg;
        rv_next    = rv_reg && rsp_stall;

        // queue fill
        if (cmd.load)
        begin
            if (a_we)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.flush)
        begin
            i_next = '0;
            if (count_reg == '0)
            begin
                ovf_next = 1'b0;
            end
        end

        // ranking
        if (cmd.rank_lat)
        begin
            key_d_next = ent_d;
            key_t_next = ent_t;
            j_next     = '0;
            rank_next  = '0;
        end
        if (cmd.scan)
        begin
            if (j_reg < count_reg)
            begin
                j_next    = j_reg + CNT_W'(1);
                pend_next = 1'b1;
                pidx_next = j_reg[IDX_W-1:0];
            end
            if (pend_reg && precedes)
            begin
                rank_next = rank_reg + IDX_W'(1);
            end
        end
        if (cmd.place)
        begin
            i_next = i_reg + IDX_W'(1);
            p_next = '0;
        end

        // run building
        if (cmd.emit_take)
        begin
            if (first_p)
            begin
                rs_next = '0;
                rc_next = CNT_W'(1);
                rt_next = b_rdata;
                p_next  = p_reg + IDX_W'(1);
            end
            else if (match)
            begin
                rc_next = rc_reg + CNT_W'(1);
                p_next  = p_reg + IDX_W'(1);
            end
            else if (stat.slot_free)
            begin
                rv_next             = 1'b1;
                rw_next.run_start   = START_W'(rs_reg);
                rw_next.run_count   = RCOUNT_W'(rc_reg);
                rw_next.run_texture = rt_reg;
                rw_next.last_run    = 1'b0;
                rw_next.dropped_any = ovf_reg;
                rs_next             = p_reg;
                rc_next             = CNT_W'(1);
                rt_next             = b_rdata;
                p_next              = p_reg + IDX_W'(1);
            end
        end
        if (cmd.emit_last && stat.slot_free)
        begin
            rv_next             = 1'b1;
            rw_next.run_start   = START_W'(rs_reg);
            rw_next.run_count   = RCOUNT_W'(rc_reg);
            rw_next.run_texture = rt_reg;
            rw_next.last_run    = 1'b1;
            rw_next.dropped_any = ovf_reg;
            count_next          = '0;
            ovf_next            = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            rv_reg    <= rv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        pidx_reg  <= pidx_next;
        rank_reg  <= rank_next;
        p_reg     <= p_next;
        key_d_reg <= key_d_next;
        key_t_reg <= key_t_next;
        rs_reg    <= rs_next;
        rc_reg    <= rc_next;
        rt_reg    <= rt_next;
        rw_reg    <= rw_next;
    end

    assign rsp_valid = rv_reg;
    assign rsp_word  = rw_reg;

endmodule
